// ===== rtl/core/b64_pkg.sv =====
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types for the base64/base64url stream decoder.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 11;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_end;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        t_status            status;
        logic               last;
        logic               byte_valid;
        logic [7:0]         data_byte;
    } t_out_item;

endpackage

// ===== rtl/core/base64url_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64url_stream_decoder
// Streaming base64 / base64url decoder, one character per beat.
// ----------------------------------------------------------------------------
// Slave channel: one character per beat in tdata; a beat with tlast set is
// the end marker and its tdata is ignored. Master channel: a decoded byte
// (tuser = 1) or, on the end marker, a status beat with tlast set carrying
// status (0 ok, 1 bad char, 2 too long) and the byte count when ok.
// Characters that do not complete a byte, and padding, produce no beat.
// A beat passes through the input register, then is decoded into the output
// register. One character is taken per cycle unless the receiver stalls;
// the only loop is the accumulator/counter update in the decode stage.
// Reset clears the decode state and both registers; the next beat starts a
// new string. When the receiver stalls, the result holds and one more input
// beat is buffered, after which tready drops until the result is taken.
// After a non-ok status the receiver drops the bytes of that string.
// ----------------------------------------------------------------------------
module base64url_stream_decoder #(
    parameter int unsigned MAX_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] data_byte, [9:8] status, [20:10] byte_count
    output logic        o_m_axis_tuser,   // [0] byte_valid
    output logic        o_m_axis_tlast
);
    import b64_pkg::*;

    t_in_item  in_item;
    t_in_item  st_item;
    t_out_item out_item;
    logic      st_valid;
    logic      st_take;

    assign in_item.char_code = i_s_axis_tdata;
    assign in_item.is_end    = i_s_axis_tlast;

    b64_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .o_item  (st_item),
        .i_take  (st_take)
    );

    b64_dec_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (st_valid),
        .i_in        (st_item),
        .o_in_take   (st_take),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (out_item)
    );

    assign o_m_axis_tdata = {3'b000, out_item.byte_count, out_item.status, out_item.data_byte};
    assign o_m_axis_tuser = out_item.byte_valid;
    assign o_m_axis_tlast = out_item.last;

endmodule

// ===== rtl/core/b64_in_stage.sv =====
// ----------------------------------------------------------------------------
// b64_in_stage
// Input register: holds one beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module b64_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  b64_pkg::t_in_item i_item,
    output logic              o_valid,
    output b64_pkg::t_in_item o_item,
    input  logic              i_take
);
    import b64_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/core/b64_dec_core.sv =====
// ----------------------------------------------------------------------------
// b64_dec_core
// Decode state, error tracking and result register.
// ----------------------------------------------------------------------------
module b64_dec_core #(
    parameter int unsigned MAX_BYTES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  b64_pkg::t_in_item  i_in,
    output logic               o_in_take,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output b64_pkg::t_out_item o_out
);
    import b64_pkg::*;

    localparam int unsigned CHAR_LIMIT = (MAX_BYTES * 4) / 3 + 8;
    localparam int unsigned CH_W       = $clog2(CHAR_LIMIT + 2);
    localparam int unsigned BY_W       = $clog2(MAX_BYTES + 2);
    localparam int unsigned EXT_W      = (BY_W > COUNT_W) ? BY_W : COUNT_W;

    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [CH_W-1:0] LIM      = CH_W'(CHAR_LIMIT);
    localparam logic [CH_W-1:0] LIM_P1   = CH_W'(CHAR_LIMIT + 1);
    localparam logic [BY_W-1:0] MAXB     = BY_W'(MAX_BYTES);

    // {ok, value}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'h00;
        r = 7'h00;
        case (c) inside
            [8'h41:8'h5A]: begin
                d = c - 8'h41;
                r = {1'b1, d[5:0]};
            end
            [8'h61:8'h7A]: begin
                d = c - 8'h47;
                r = {1'b1, d[5:0]};
            end
            [8'h30:8'h39]: begin
                d = c + 8'h04;
                r = {1'b1, d[5:0]};
            end
            CH_MINUS, CH_PLUS: r = {1'b1, 6'd62};
            CH_UNDER, CH_SLASH: r = {1'b1, 6'd63};
            default: r = 7'h00;
        endcase
        return r;
    endfunction

    logic [11:0]     r_acc,   n_acc;
    logic [3:0]      r_held,  n_held;
    logic [CH_W-1:0] r_total, n_total;
    logic [CH_W-1:0] r_pads,  n_pads;
    logic [BY_W-1:0] r_bytes, n_bytes;
    logic            r_bad,   n_bad;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out,   n_out;

    logic            take;
    logic [6:0]      sext;
    logic [CH_W:0]   sum;
    logic [11:0]     acc_next;
    logic [3:0]      held_sum;
    logic [3:0]      held_new;
    logic [11:0]     shifted;
    logic [EXT_W-1:0] cnt_ext;

    assign o_in_take   = take;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        take     = i_in_valid && (!r_out_valid || i_out_ready);
        sext     = sextet_of(i_in.char_code);
        sum      = {1'b0, r_total} + {1'b0, r_pads} + {{CH_W{1'b0}}, 1'b1};
        acc_next = {r_acc[5:0], sext[5:0]};
        held_sum = r_held + 4'd6;
        held_new = held_sum - 4'd8;
        shifted  = acc_next >> held_new;
        cnt_ext  = EXT_W'(r_bytes);

        n_acc       = r_acc;
        n_held      = r_held;
        n_total     = r_total;
        n_pads      = r_pads;
        n_bytes     = r_bytes;
        n_bad       = r_bad;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (take) begin
            if (i_in.is_end) begin
                n_out            = '0;
                n_out.last       = 1'b1;
                n_out_valid      = 1'b1;
                if (r_total > LIM) begin
                    n_out.status = ST_TOO_LONG;
                end else if (r_bad) begin
                    n_out.status = ST_BAD_CHAR;
                end else if (r_bytes > MAXB) begin
                    n_out.status = ST_TOO_LONG;
                end else begin
                    n_out.status     = ST_OK;
                    n_out.byte_count = cnt_ext[COUNT_W-1:0];
                end
                n_acc   = '0;
                n_held  = '0;
                n_total = '0;
                n_pads  = '0;
                n_bytes = '0;
                n_bad   = 1'b0;
            end else if (i_in.char_code == CH_PAD) begin
                if (r_pads <= LIM) begin
                    n_pads = r_pads + 1'b1;
                end
            end else begin
                n_pads  = '0;
                n_bad   = r_bad || (r_pads != '0) || !sext[6];
                n_total = (sum > {1'b0, LIM_P1}) ? LIM_P1 : sum[CH_W-1:0];
                if (!n_bad && (n_total <= LIM) && (r_bytes <= MAXB)) begin
                    n_acc  = acc_next;
                    n_held = held_sum;
                    if (held_sum >= 4'd8) begin
                        n_held  = held_new;
                        n_bytes = r_bytes + 1'b1;
                        if (n_bytes <= MAXB) begin
                            n_out            = '0;
                            n_out.byte_valid = 1'b1;
                            n_out.data_byte  = shifted[7:0];
                            n_out_valid      = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_held      <= '0;
            r_total     <= '0;
            r_pads      <= '0;
            r_bytes     <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_held      <= n_held;
            r_total     <= n_total;
            r_pads      <= n_pads;
            r_bytes     <= n_bytes;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_held_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == 4'd0) || (r_held == 4'd2) || (r_held == 4'd4) || (r_held == 4'd6))
        else $error("bits held out of range");

    a_bytes_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= MAXB + 1'b1)
        else $error("byte counter past saturation");

    a_counts_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total <= LIM_P1) && (r_pads <= LIM_P1))
        else $error("character counters past saturation");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.byte_valid != r_out.last))
        else $error("result is neither or both byte and status");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_in.is_end) |=> (r_held == 4'd0) && (r_bytes == '0) && !r_bad
                                  && (r_pads == '0) && (r_total == '0))
        else $error("state not cleared after end beat");

endmodule
